>>> design/tpb_pkg.sv
`timescale 1ns / 1ps

package tpb_pkg;

	localparam int SLOTS_DEF = 8;

	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic [1:0] REG_BATCH_MODE  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT     = 2'd1;
	localparam logic [1:0] REG_CRIT_PRIO   = 2'd2;
	localparam logic [1:0] REG_NONCE_START = 2'd3;

	localparam logic [1:0]  BATCH_MODE_RST = 2'd1;
	localparam logic [15:0] TIMEOUT_RST    = 16'd50;
	localparam logic [7:0]  CRIT_PRIO_RST  = 8'h03;
	localparam logic [31:0] NONCE_RST      = 32'd0;

	localparam logic [1:0] MODE_MANUAL    = 2'd0;
	localparam logic [1:0] MODE_TIMED     = 2'd1;
	localparam logic [1:0] MODE_IMMEDIATE = 2'd2;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] STAT_ADD_OK   = 2'd0;
	localparam logic [1:0] STAT_ADD_FULL = 2'd1;
	localparam logic [1:0] STAT_TICK     = 2'd2;
	localparam logic [1:0] STAT_FLUSHED  = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DESC   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_REASON,
		ST_STATUS,
		ST_FLUSH_CHK,
		ST_FLUSH_EMIT
	} state_t;

	typedef struct packed {
		logic [31:0] tick;
		logic [1:0]  cls;
		logic [7:0]  len;
		logic [7:0]  typ;
		logic [15:0] dest;
		logic [7:0]  prio;
	} slot_t;

	typedef struct packed {
		logic [1:0]  batch_mode;
		logic [15:0] timeout_ticks;
		logic [7:0]  crit_prio;
		logic        nonce_ld;
		logic [31:0] nonce_val;
	} cfg_t;

endpackage

>>> design/tpb_ram.sv
`timescale 1ns / 1ps

module tpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/tpb_cmp_unit.sv
`timescale 1ns / 1ps

module tpb_cmp_unit (
	input  logic [31:0] opa,
	input  logic [31:0] opb,
	input  logic [31:0] limit,
	output logic        ge
);

	logic [31:0] diff;

	assign diff = opa - opb;
	assign ge   = (diff >= limit);

endmodule

>>> design/tpb_cfg.sv
`timescale 1ns / 1ps

module tpb_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tpb_pkg::CFG_AW-1:0] paddr,
	input  logic [tpb_pkg::CFG_DW-1:0] pwdata,
	output logic [tpb_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output tpb_pkg::cfg_t              cfg
);

	logic [1:0]  mode_q;
	logic [15:0] timeout_q;
	logic [7:0]  crit_q;
	logic [31:0] nonce_start_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= tpb_pkg::BATCH_MODE_RST;
			timeout_q     <= tpb_pkg::TIMEOUT_RST;
			crit_q        <= tpb_pkg::CRIT_PRIO_RST;
			nonce_start_q <= tpb_pkg::NONCE_RST;
		end else if (wr) begin
			case (idx)
				tpb_pkg::REG_BATCH_MODE:  mode_q        <= pwdata[1:0];
				tpb_pkg::REG_TIMEOUT:     timeout_q     <= pwdata[15:0];
				tpb_pkg::REG_CRIT_PRIO:   crit_q        <= pwdata[7:0];
				tpb_pkg::REG_NONCE_START: nonce_start_q <= pwdata;
				default:                  mode_q        <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tpb_pkg::REG_BATCH_MODE:  prdata = {30'd0, mode_q};
			tpb_pkg::REG_TIMEOUT:     prdata = {16'd0, timeout_q};
			tpb_pkg::REG_CRIT_PRIO:   prdata = {24'd0, crit_q};
			tpb_pkg::REG_NONCE_START: prdata = nonce_start_q;
			default:                  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.batch_mode    = mode_q;
		cfg.timeout_ticks = timeout_q;
		cfg.crit_prio     = crit_q;
		cfg.nonce_ld      = wr && (idx == tpb_pkg::REG_NONCE_START);
		cfg.nonce_val     = pwdata;
	end

endmodule

>>> design/tx_packet_batcher.sv
`timescale 1ns / 1ps

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+----------------------------------------------
// command   | in_valid / in_stall         | cmd dest_id msg_type pkt_len reliability
//           |                             | priority_req now
// result    | out_valid / out_stall       | kind status reasons queued out_dest out_type
//           |                             | out_len out_class nonce queued_at last
// config    | psel penable pwrite pready  | paddr pwdata prdata
//
// After a command is accepted the sequencer steps through SCAN, SCAN_LAST, DECIDE, REASON and
// STATUS, where the status transaction is offered. It walks every slot through the slot RAM
// (one write port, one read port), sharing one subtract-and-compare unit for the priority
// test, the new entry's priority and the timeout. A flush then checks the slots in order,
// skipping empty ones, and for each held descriptor does a RAM read, then an output. in_stall
// is high from acceptance until the last result is loaded; a stalled output holds the sequencer.
// Reset clears control state, valid bits and counters, and returns config registers to defaults.

module tx_packet_batcher #(
	parameter int SLOTS = tpb_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tpb_pkg::CFG_AW-1:0] paddr,
	input  logic [tpb_pkg::CFG_DW-1:0] pwdata,
	output logic [tpb_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [15:0]                dest_id,
	input  logic [7:0]                 msg_type,
	input  logic [7:0]                 pkt_len,
	input  logic [1:0]                 reliability,
	input  logic [7:0]                 priority_req,
	input  logic [31:0]                now,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [1:0]                 status,
	output logic [2:0]                 reasons,
	output logic [3:0]                 queued,
	output logic [15:0]                out_dest,
	output logic [7:0]                 out_type,
	output logic [7:0]                 out_len,
	output logic [1:0]                 out_class,
	output logic [31:0]                nonce,
	output logic [31:0]                queued_at,
	output logic                       last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

	tpb_pkg::cfg_t   cfg;
	tpb_pkg::state_t state_q, state_d;
	tpb_pkg::slot_t  wr_slot, rd_slot;

	logic [1:0]       cmd_q;
	logic [15:0]      dest_q;
	logic [7:0]       type_q;
	logic [7:0]       len_q;
	logic [1:0]       cls_q;
	logic [7:0]       prio_q;
	logic [31:0]      now_q;

	logic [SLOTS-1:0] valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [31:0]      first_tick_q;
	logic [31:0]      nonce_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] scan_idx_s1;
	logic             scan_v_s1;
	logic [IDX_W-1:0] free_idx_q;
	logic             free_found_q;
	logic             pri_hit_q;
	logic             flush_q;
	logic [1:0]       stat_q;
	logic [2:0]       reasons_q;

	logic             out_valid_q;
	logic             out_free;
	logic             in_take;
	logic             ram_we;
	logic             load_status;
	logic             load_desc;
	logic             full;
	logic             add_ok;
	logic             tmo;

	logic [31:0]      cmp_a, cmp_b, cmp_c;
	logic             cmp_ge;

	tpb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpb_ram #(
		.WIDTH ($bits(tpb_pkg::slot_t)),
		.DEPTH (SLOTS),
		.AW    (IDX_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata (wr_slot),
		.raddr (idx_q),
		.rdata (rd_slot)
	);

	tpb_cmp_unit u_cmp (
		.opa   (cmp_a),
		.opb   (cmp_b),
		.limit (cmp_c),
		.ge    (cmp_ge)
	);

	always_comb begin
		wr_slot.tick = now_q;
		wr_slot.cls  = cls_q;
		wr_slot.len  = len_q;
		wr_slot.typ  = type_q;
		wr_slot.dest = dest_q;
		wr_slot.prio = prio_q;
	end

	always_comb begin
		case (state_q)
			tpb_pkg::ST_REASON: begin
				cmp_a = now_q;
				cmp_b = first_tick_q;
				cmp_c = {16'd0, cfg.timeout_ticks};
			end
			tpb_pkg::ST_DECIDE: begin
				cmp_a = {24'd0, prio_q};
				cmp_b = '0;
				cmp_c = {24'd0, cfg.crit_prio};
			end
			default: begin
				cmp_a = {24'd0, rd_slot.prio};
				cmp_b = '0;
				cmp_c = {24'd0, cfg.crit_prio};
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (cnt_q >= CNT_FULL);
	assign add_ok   = (cmd_q == tpb_pkg::CMD_ADD) && !full && free_found_q;
	assign tmo      = (cfg.batch_mode == tpb_pkg::MODE_TIMED)
	                  && (cfg.timeout_ticks != 16'd0) && cmp_ge;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tpb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tpb_pkg::ST_SCAN;
				end
			end
			tpb_pkg::ST_SCAN: begin
				if (idx_q == IDX_LAST) begin
					state_d = tpb_pkg::ST_SCAN_LAST;
				end
			end
			tpb_pkg::ST_SCAN_LAST: state_d = tpb_pkg::ST_DECIDE;
			tpb_pkg::ST_DECIDE:    state_d = tpb_pkg::ST_REASON;
			tpb_pkg::ST_REASON:    state_d = tpb_pkg::ST_STATUS;
			tpb_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = (flush_q && cnt_q != '0) ? tpb_pkg::ST_FLUSH_CHK
					                                    : tpb_pkg::ST_IDLE;
				end
			end
			tpb_pkg::ST_FLUSH_CHK: begin
				if (valid_q[idx_q]) begin
					state_d = tpb_pkg::ST_FLUSH_EMIT;
				end
			end
			tpb_pkg::ST_FLUSH_EMIT: begin
				if (out_free) begin
					state_d = (rem_q == CNT_W'(1)) ? tpb_pkg::ST_IDLE
					                               : tpb_pkg::ST_FLUSH_CHK;
				end
			end
			default: state_d = tpb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != tpb_pkg::ST_IDLE);
		in_take     = in_valid && (state_q == tpb_pkg::ST_IDLE);
		ram_we      = (state_q == tpb_pkg::ST_DECIDE) && add_ok;
		load_status = (state_q == tpb_pkg::ST_STATUS) && out_free;
		load_desc   = (state_q == tpb_pkg::ST_FLUSH_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= cmd;
			dest_q <= dest_id;
			type_q <= msg_type;
			len_q  <= pkt_len;
			cls_q  <= reliability;
			prio_q <= priority_req;
			now_q  <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cnt_q        <= '0;
			rem_q        <= '0;
			first_tick_q <= '0;
			nonce_q      <= '0;
			idx_q        <= '0;
			scan_idx_s1  <= '0;
			scan_v_s1    <= 1'b0;
			free_idx_q   <= '0;
			free_found_q <= 1'b0;
			pri_hit_q    <= 1'b0;
			flush_q      <= 1'b0;
			stat_q       <= tpb_pkg::STAT_TICK;
			reasons_q    <= '0;
		end else begin
			if (cfg.nonce_ld) begin
				nonce_q <= cfg.nonce_val;
			end

			// scan pipeline: the RAM read data is registered, so scan_idx_s1 tags the slot whose data rd_slot holds
			if (scan_v_s1) begin
				if (valid_q[scan_idx_s1] && cmp_ge) begin
					pri_hit_q <= 1'b1;
				end
				if (!valid_q[scan_idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_idx_s1;
				end
			end

			case (state_q)
				tpb_pkg::ST_IDLE: begin
					if (in_take) begin
						idx_q        <= '0;
						scan_v_s1    <= 1'b0;
						free_found_q <= 1'b0;
						pri_hit_q    <= 1'b0;
					end
				end
				tpb_pkg::ST_SCAN: begin
					scan_v_s1   <= 1'b1;
					scan_idx_s1 <= idx_q;
					if (idx_q != IDX_LAST) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				tpb_pkg::ST_SCAN_LAST: begin
					scan_v_s1 <= 1'b0;
				end
				tpb_pkg::ST_DECIDE: begin
					case (cmd_q)
						tpb_pkg::CMD_ADD: begin
							if (add_ok) begin
								valid_q[free_idx_q] <= 1'b1;
								cnt_q               <= cnt_q + CNT_W'(1);
								if (cnt_q == '0) begin
									first_tick_q <= now_q;
								end
								pri_hit_q <= pri_hit_q || cmp_ge;
								flush_q   <= (cfg.batch_mode == tpb_pkg::MODE_IMMEDIATE)
								             || cmp_ge;
								stat_q    <= tpb_pkg::STAT_ADD_OK;
							end else begin
								flush_q <= 1'b0;
								stat_q  <= tpb_pkg::STAT_ADD_FULL;
							end
						end
						tpb_pkg::CMD_FLUSH: begin
							flush_q <= 1'b1;
							stat_q  <= tpb_pkg::STAT_FLUSHED;
						end
						default: begin
							flush_q <= 1'b0;
							stat_q  <= tpb_pkg::STAT_TICK;
						end
					endcase
				end
				tpb_pkg::ST_REASON: begin
					if (cnt_q == '0) begin
						reasons_q <= '0;
					end else begin
						reasons_q <= {pri_hit_q, tmo, full};
						if (cmd_q == tpb_pkg::CMD_TICK && (tmo || full)) begin
							flush_q <= 1'b1;
						end
					end
				end
				tpb_pkg::ST_STATUS: begin
					if (out_free) begin
						rem_q <= cnt_q;
						idx_q <= '0;
					end
				end
				tpb_pkg::ST_FLUSH_CHK: begin
					if (!valid_q[idx_q]) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				tpb_pkg::ST_FLUSH_EMIT: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b0;
						nonce_q        <= nonce_q + 32'd1;
						rem_q          <= rem_q - CNT_W'(1);
						idx_q          <= idx_q + IDX_W'(1);
						if (rem_q == CNT_W'(1)) begin
							cnt_q <= '0;
						end
					end
				end
				default: begin
					scan_v_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_status || load_desc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_status) begin
			kind      <= tpb_pkg::KIND_STATUS;
			status    <= stat_q;
			reasons   <= reasons_q;
			queued    <= 4'(cnt_q);
			out_dest  <= '0;
			out_type  <= '0;
			out_len   <= '0;
			out_class <= '0;
			nonce     <= '0;
			queued_at <= '0;
			last      <= !(flush_q && cnt_q != '0);
		end else if (load_desc) begin
			kind      <= tpb_pkg::KIND_DESC;
			status    <= '0;
			reasons   <= '0;
			queued    <= '0;
			out_dest  <= rd_slot.dest;
			out_type  <= rd_slot.typ;
			out_len   <= rd_slot.len;
			out_class <= rd_slot.cls;
			nonce     <= nonce_q + 32'd1;
			queued_at <= rd_slot.tick;
			last      <= (rem_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> tb/tx_packet_batcher_tb.sv
`timescale 1ns / 1ps

module tx_packet_batcher_tb;
	import tpb_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam logic [1:0] CMD_RSVD  = 2'd3;
	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] dest;
		logic [7:0]  typ;
		logic [7:0]  len;
		logic [1:0]  rel;
		logic [7:0]  prio;
		logic [31:0] t;
	} tx_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [2:0]  reasons;
		logic [3:0]  queued;
		logic [15:0] dest;
		logic [7:0]  typ;
		logic [7:0]  len;
		logic [1:0]  cls;
		logic [31:0] nonce;
		logic [31:0] queued_at;
		logic        last;
	} tx_result_t;

	typedef struct packed {
		bit         typed;
		logic [1:0] st;
		logic [2:0] rs;
		logic [3:0] q;
		tx_cmd_t    c;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [CFG_DW-1:0]   pwdata;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid, in_stall;
	logic [1:0]          cmd;
	logic [15:0]         dest_id;
	logic [7:0]          msg_type, pkt_len;
	logic [1:0]          reliability;
	logic [7:0]          priority_req;
	logic [31:0]         now;
	logic                out_valid, out_stall;
	logic                kind;
	logic [1:0]          status;
	logic [2:0]          reasons;
	logic [3:0]          queued;
	logic [15:0]         out_dest;
	logic [7:0]          out_type, out_len;
	logic [1:0]          out_class;
	logic [31:0]         nonce, queued_at;
	logic                last;

	bit          slot_held [SLOTS];
	slot_t       slot_store [SLOTS];
	logic [3:0]  held_count;
	logic [31:0] batch_start;
	logic [31:0] nonce_ctr;
	logic [1:0]  mode_r;
	logic [15:0] timeout_r;
	logic [7:0]  crit_r;

	tx_result_t  pending_results[$];
	plan_row_t   directed_plan[$];
	int          errors = 0;
	bit          no_idle = 1'b0;
	bit          start_hold = 1'b0;
	logic [31:0] tick_now;

	tx_packet_batcher #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .dest_id(dest_id), .msg_type(msg_type), .pkt_len(pkt_len),
		.reliability(reliability), .priority_req(priority_req), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .status(status), .reasons(reasons), .queued(queued),
		.out_dest(out_dest), .out_type(out_type), .out_len(out_len),
		.out_class(out_class), .nonce(nonce), .queued_at(queued_at), .last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [2:0] flush_reasons(input logic [31:0] t);
		logic [2:0]  r;
		logic [31:0] age;
		r = 3'b000;
		age = t - batch_start;
		if (held_count != 0) begin
			if (held_count >= SLOTS)
				r[0] = 1'b1;
			if (mode_r == MODE_TIMED && timeout_r != 0 && age >= {16'd0, timeout_r})
				r[1] = 1'b1;
			for (int i = 0; i < SLOTS; i++)
				if (slot_held[i] && slot_store[i].prio >= crit_r)
					r[2] = 1'b1;
		end
		return r;
	endfunction

	task automatic batch_step(input plan_row_t row);
		logic [1:0] stat;
		bit         do_flush;
		int         slot;
		int         ndesc;
		logic [2:0] r;
		tx_result_t res;
		do_flush = 1'b0;
		slot = -1;
		case (row.c.cmd)
			CMD_ADD: begin
				if (held_count < SLOTS)
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && !slot_held[i])
							slot = i;
				if (slot < 0) begin
					stat = STAT_ADD_FULL;
				end else begin
					slot_held[slot] = 1'b1;
					slot_store[slot].dest = row.c.dest;
					slot_store[slot].typ = row.c.typ;
					slot_store[slot].len = row.c.len;
					slot_store[slot].cls = row.c.rel;
					slot_store[slot].prio = row.c.prio;
					slot_store[slot].tick = row.c.t;
					if (held_count == 0)
						batch_start = row.c.t;
					held_count = held_count + 4'd1;
					stat = STAT_ADD_OK;
					if (mode_r == MODE_IMMEDIATE || row.c.prio >= crit_r)
						do_flush = 1'b1;
				end
			end
			CMD_FLUSH: begin
				stat = STAT_FLUSHED;
				do_flush = 1'b1;
			end
			default: stat = STAT_TICK;
		endcase
		r = flush_reasons(row.c.t);
		if (row.c.cmd == CMD_TICK && r[1:0] != 2'b00)
			do_flush = 1'b1;
		ndesc = 0;
		if (do_flush)
			for (int i = 0; i < SLOTS; i++)
				if (slot_held[i])
					ndesc++;
		res = '0;
		res.kind = KIND_STATUS;
		res.status = row.typed ? row.st : stat;
		res.reasons = row.typed ? row.rs : r;
		res.queued = row.typed ? row.q : held_count;
		res.last = (ndesc == 0);
		pending_results.push_back(res);
		if (do_flush) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_held[i]) begin
					nonce_ctr = nonce_ctr + 32'd1;
					ndesc--;
					res = '0;
					res.kind = KIND_DESC;
					res.dest = slot_store[i].dest;
					res.typ = slot_store[i].typ;
					res.len = slot_store[i].len;
					res.cls = slot_store[i].cls;
					res.nonce = nonce_ctr;
					res.queued_at = slot_store[i].tick;
					res.last = (ndesc == 0);
					slot_held[i] = 1'b0;
					pending_results.push_back(res);
				end
			end
			held_count = 4'd0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction kind %0h status %0h",
					$time, kind, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("status", want.status, status);
				check_field("reasons", want.reasons, reasons);
				check_field("queued", want.queued, queued);
				check_field("out_dest", want.dest, out_dest);
				check_field("out_type", want.typ, out_type);
				check_field("out_len", want.len, out_len);
				check_field("out_class", want.cls, out_class);
				check_field("nonce", want.nonce, nonce);
				check_field("queued_at", want.queued_at, queued_at);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (start_hold) begin
				start_hold = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 31);
			end
		end
	end

	task automatic send_command(input plan_row_t row);
		while (!no_idle && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= row.c.cmd;
		dest_id <= row.c.dest;
		msg_type <= row.c.typ;
		pkt_len <= row.c.len;
		reliability <= row.c.rel;
		priority_req <= row.c.prio;
		now <= row.c.t;
		do
			@(posedge clk);
		while (in_stall);
		batch_step(row);
		@(negedge clk);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic drain(input int settle);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			errors++;
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_BATCH_MODE:  mode_r = val[1:0];
			REG_TIMEOUT:     timeout_r = val[15:0];
			REG_CRIT_PRIO:   crit_r = val[7:0];
			REG_NONCE_START: nonce_ctr = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [1:0] mode, input logic [15:0] tmo,
			input logic [7:0] crit, input logic [31:0] nonce_start);
		set_reg(REG_BATCH_MODE, {30'd0, mode});
		set_reg(REG_TIMEOUT, {16'd0, tmo});
		set_reg(REG_CRIT_PRIO, {24'd0, crit});
		set_reg(REG_NONCE_START, nonce_start);
	endtask

	task automatic plan(input bit typed, input logic [1:0] st, input logic [2:0] rs,
			input logic [3:0] q, input logic [1:0] c, input logic [15:0] dest,
			input logic [7:0] typ, input logic [7:0] len, input logic [1:0] rel,
			input logic [7:0] prio, input logic [31:0] t);
		plan_row_t row;
		row.typed = typed;
		row.st = st;
		row.rs = rs;
		row.q = q;
		row.c.cmd = c;
		row.c.dest = dest;
		row.c.typ = typ;
		row.c.len = len;
		row.c.rel = rel;
		row.c.prio = prio;
		row.c.t = t;
		directed_plan.push_back(row);
	endtask

	task automatic run_random(input int count, input int stride, input int hold_at);
		plan_row_t row;
		int        k;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				start_hold = 1'b1;
			if (i == count / 2 || $urandom_range(39) == 0)
				wait_results();
			row = '0;
			k = $urandom_range(99);
			row.c.cmd = (k < 58) ? CMD_ADD : (k < 83) ? CMD_TICK :
				(k < 95) ? CMD_FLUSH : CMD_RSVD;
			row.c.dest = 16'($urandom);
			row.c.typ = 8'($urandom);
			row.c.len = 8'($urandom);
			row.c.rel = 2'($urandom);
			if (crit_r == 0 || $urandom_range(7) == 0)
				row.c.prio = 8'($urandom_range(crit_r, 255));
			else
				row.c.prio = 8'($urandom_range(0, crit_r - 1));
			tick_now = tick_now + $urandom_range(0, stride);
			row.c.t = ($urandom_range(15) == 0) ? $urandom : tick_now;
			send_command(row);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_ADD;
		dest_id = '0;
		msg_type = '0;
		pkt_len = '0;
		reliability = '0;
		priority_req = '0;
		now = '0;
		for (int i = 0; i < SLOTS; i++)
			slot_held[i] = 1'b0;
		held_count = 4'd0;
		batch_start = 32'd0;
		nonce_ctr = NONCE_RST;
		mode_r = BATCH_MODE_RST;
		timeout_r = TIMEOUT_RST;
		crit_r = CRIT_PRIO_RST;
		tick_now = $urandom;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		plan(1, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'd0);
		plan(1, STAT_FLUSHED,  3'b000, 4'd0, CMD_FLUSH, 16'h0000, 8'h00, 8'h00, 2'd0, 8'h00,
			32'hFFFF_FFFF);
		plan(1, STAT_TICK,     3'b000, 4'd0, CMD_RSVD,  16'hFFFF, 8'hFF, 8'hFF, 2'd3, 8'hFF, 32'd0);
		plan(1, STAT_ADD_OK,   3'b000, 4'd1, CMD_ADD,   16'hFFFF, 8'hFF, 8'hFF, 2'd3, 8'h00, 32'd100);
		plan(1, STAT_ADD_OK,   3'b000, 4'd2, CMD_ADD,   16'h0000, 8'h00, 8'h00, 2'd0, 8'h02, 32'd120);
		plan(0, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'd149);
		plan(0, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'd150);
		plan(1, STAT_ADD_OK,   3'b100, 4'd1, CMD_ADD,   16'h1234, 8'h5A, 8'hA5, 2'd1, 8'h03, 32'd160);
		for (int i = 0; i < SLOTS - 1; i++)
			plan(0, STAT_ADD_OK, 3'b000, 4'd0, CMD_ADD, 16'(16'h1111 * i), 8'(8'h11 * i),
				8'(8'h22 * i), i[1:0], 8'h00, 32'd200);
		plan(1, STAT_ADD_OK,   3'b001, 4'd8, CMD_ADD,   16'hBEEF, 8'h77, 8'h88, 2'd2, 8'h01, 32'd200);
		plan(1, STAT_ADD_FULL, 3'b001, 4'd8, CMD_ADD,   16'hDEAD, 8'h99, 8'h66, 2'd3, 8'hFF, 32'd201);
		plan(0, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'd201);
		plan(0, STAT_ADD_OK,   3'b000, 4'd0, CMD_ADD,   16'hA5A5, 8'h3C, 8'hC3, 2'd2, 8'h00,
			32'hFFFF_FFF0);
		plan(0, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'h20);
		plan(0, STAT_TICK,     3'b000, 4'd0, CMD_TICK,  16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'h22);
		plan(0, STAT_ADD_OK,   3'b000, 4'd0, CMD_ADD,   16'h5A5A, 8'hC3, 8'h3C, 2'd1, 8'h02, 32'd5);
		plan(0, STAT_FLUSHED,  3'b000, 4'd0, CMD_FLUSH, 16'h0000, 8'h00, 8'h00, 2'd0, 8'h00, 32'd6);
		foreach (directed_plan[i])
			send_command(directed_plan[i]);
		drain(4);

		reconfigure(MODE_MANUAL, 16'd0, 8'd255, 32'hFFFF_FFFD);
		run_random(48, 50, -1);
		drain(4);

		reconfigure(MODE_IMMEDIATE, 16'hFFFF, 8'd0, $urandom);
		run_random(40, 10, -1);
		drain(4);

		no_idle = 1'b1;
		reconfigure(MODE_TIMED, 16'd20, 8'd200, 32'd0);
		run_random(52, 8, 5);
		drain(4);
		no_idle = 1'b0;

		reconfigure(MODE_RSVD, 16'($urandom), 8'($urandom_range(1, 255)), $urandom);
		run_random(48, 100, -1);
		drain(4);

		reconfigure(MODE_TIMED, 16'hFFFF, 8'd128, 32'hFFFF_FFFF);
		run_random(52, 20000, -1);
		drain(2 * SLOTS + 10);

		if (errors == 0)
			$display("tx_packet_batcher_tb: clean");
		else
			$display("tx_packet_batcher_tb: errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tx_packet_batcher_tb: errors");
		$finish;
	end

endmodule
